// ----- rtl/dual_mode_pid_four_wheel_core_assert.svh -----
// Assertion macros for the checker file of the wheel PID core.
// No dependencies; included by bare file name.
`ifndef DUAL_MODE_PID_FOUR_WHEEL_CORE_ASSERT_SVH
`define DUAL_MODE_PID_FOUR_WHEEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dmpid_pkg.sv -----
// Shared widths, register indexes, reset values and lane control type
// of the wheel PID core. No dependencies.
package dmpid_pkg;

  localparam int unsigned MEAS_W  = 31;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned X_W     = 35;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned CLAMP_W = 31;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NSTG    = 5;

  localparam int     ERR_SUM_BOUND = 10000;
  localparam longint SUM_CAP       = 64'sd2147483647;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P = 32'd576717;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I = 32'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D = 32'd0;
  localparam logic [CLAMP_W-1:0] RST_ICLAMP = 31'd327680000;
  localparam logic [CLAMP_W-1:0] RST_OCLAMP = 31'd589824000;

  typedef enum logic [IDX_W-1:0] {
    CFG_INCR_MODE = 3'd0,
    CFG_GAIN_P    = 3'd1,
    CFG_GAIN_I    = 3'd2,
    CFG_GAIN_D    = 3'd3,
    CFG_ICLAMP    = 3'd4,
    CFG_OCLAMP    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [NSTG-1:0] load;
    logic            st_upd;
    logic            acc_upd;
    logic            incr;
  } lane_ctl_t;

endpackage

// ----- rtl/dmpid_lane.sv -----
// One PID lane: error state, split gain products, term sums and the
// saturating output accumulator. Depends on dmpid_pkg.
module dmpid_lane #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned TermW = dmpid_pkg::GAIN_W + dmpid_pkg::X_W + 2 - FRAC_BITS,
  localparam int unsigned SumW  = TermW + 2,
  localparam int unsigned PreW  = (SumW > dmpid_pkg::ACC_W) ? SumW : dmpid_pkg::ACC_W
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dmpid_pkg::lane_ctl_t                 ctl_i,
  input  logic signed [dmpid_pkg::MEAS_W-1:0]  meas_i,
  input  logic signed [dmpid_pkg::MEAS_W-1:0]  targ_i,
  input  logic        [dmpid_pkg::GAIN_W-1:0]  gain_p_i,
  input  logic        [dmpid_pkg::GAIN_W-1:0]  gain_i_i,
  input  logic        [dmpid_pkg::GAIN_W-1:0]  gain_d_i,
  input  logic        [dmpid_pkg::CLAMP_W-1:0] ilim_i,
  output logic signed [PreW-1:0]               pre_o
);
  import dmpid_pkg::*;

  localparam int unsigned HiW  = X_W - FRAC_BITS;
  localparam int unsigned HpW  = GAIN_W + 1 + HiW;
  localparam int unsigned AddW = PreW + 1;
  localparam longint SumLimRaw = longint'(ERR_SUM_BOUND) <<< FRAC_BITS;
  localparam longint SumLimL   = (SumLimRaw > SUM_CAP) ? SUM_CAP : SumLimRaw;
  localparam logic signed [ERR_W:0]  SumLim = (ERR_W+1)'(SumLimL);
  localparam logic signed [AddW-1:0] AccMax = AddW'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [AddW-1:0] AccMin = -AccMax - AddW'(1);

  // Stage 0: error, differences and operand selection.
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W:0]   d1, nsum, nsum_clamped;
  logic signed [X_W-1:0]   d2;
  logic signed [X_W-1:0]   x_d [3];
  logic signed [X_W-1:0]   x_q [3];
  logic signed [ERR_W-1:0] e1_q, e2_q, sum_q;

  assign err  = ERR_W'($signed({targ_i[MEAS_W-1], targ_i}) -
                       $signed({meas_i[MEAS_W-1], meas_i}));
  assign d1   = (ERR_W+1)'(err) - (ERR_W+1)'(e1_q);
  assign d2   = X_W'(err) - (X_W'(e1_q) <<< 1) + X_W'(e2_q);
  assign nsum = (ERR_W+1)'(sum_q) + (ERR_W+1)'(err);

  always_comb begin
    if (nsum > SumLim) begin
      nsum_clamped = SumLim;
    end else if (nsum < -SumLim) begin
      nsum_clamped = -SumLim;
    end else begin
      nsum_clamped = nsum;
    end
    if (ctl_i.incr) begin
      x_d[0] = X_W'(d1);
      x_d[1] = X_W'(err);
      x_d[2] = d2;
    end else begin
      // The integral term works on the sum from before this item.
      x_d[0] = X_W'(err);
      x_d[1] = X_W'(sum_q);
      x_d[2] = X_W'(d1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q  <= '0;
      e2_q  <= '0;
      sum_q <= '0;
    end else if (ctl_i.st_upd) begin
      e2_q <= e1_q;
      e1_q <= err;
      if (!ctl_i.incr) begin
        sum_q <= ERR_W'(nsum_clamped);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      x_q <= x_d;
    end
  end

  // Stage 1: each product is split at the binary point into a signed high
  // part and an unsigned low part, which keeps both multipliers narrow.
  logic [GAIN_W-1:0]           gain [3];
  logic signed [HpW-1:0]       hp_d [3];
  logic signed [HpW-1:0]       hp_q [3];
  logic [GAIN_W+FRAC_BITS-1:0] lp_full [3];
  logic [GAIN_W-1:0]           lp_q [3];

  assign gain[0] = gain_p_i;
  assign gain[1] = gain_i_i;
  assign gain[2] = gain_d_i;

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      hp_d[t]    = $signed({1'b0, gain[t]}) * $signed(x_q[t][X_W-1:FRAC_BITS]);
      lp_full[t] = gain[t] * x_q[t][FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      for (int t = 0; t < 3; t++) begin
        hp_q[t] <= hp_d[t];
        lp_q[t] <= lp_full[t][GAIN_W+FRAC_BITS-1:FRAC_BITS];
      end
    end
  end

  // Stage 2: recombine the halves and limit the integral term.
  logic signed [TermW-1:0] term [3];
  logic signed [TermW-1:0] term_q [3];
  logic signed [TermW-1:0] ilim_s;

  assign ilim_s = $signed({{(TermW-CLAMP_W){1'b0}}, ilim_i});

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      term[t] = TermW'(hp_q[t]) + $signed({{(TermW-GAIN_W){1'b0}}, lp_q[t]});
    end
    if (term[1] > ilim_s) begin
      term[1] = ilim_s;
    end else if (term[1] < -ilim_s) begin
      term[1] = -ilim_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      term_q <= term;
    end
  end

  // Stage 3: sum of the three terms.
  logic signed [SumW-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      s_q <= SumW'(term_q[0]) + SumW'(term_q[1]) + SumW'(term_q[2]);
    end
  end

  // Stage 4: accumulator of the incremental form, saturating at 48 bits.
  logic signed [AddW-1:0]  acc_sum, acc_sat;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [PreW-1:0]  pre_d, pre_q;

  assign acc_sum = AddW'(acc_q) + AddW'(s_q);

  always_comb begin
    if (acc_sum > AccMax) begin
      acc_sat = AccMax;
    end else if (acc_sum < AccMin) begin
      acc_sat = AccMin;
    end else begin
      acc_sat = acc_sum;
    end
    acc_d = ACC_W'(acc_sat);
    pre_d = ctl_i.incr ? PreW'(acc_d) : PreW'(s_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc_upd) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[4]) begin
      pre_q <= pre_d;
    end
  end

  assign pre_o = pre_q;

endmodule

// ----- rtl/dmpid_merge.sv -----
// Merging stage: clamps every lane's value to the output limit, applies
// zero mode and registers the packed result item. Depends on dmpid_pkg.
module dmpid_merge #(
  parameter int unsigned LANES = 4,
  parameter int unsigned PRE_W = 54
) (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic                                  zero_i,
  input  logic        [dmpid_pkg::CLAMP_W-1:0]  oclim_i,
  input  logic signed [PRE_W-1:0]               pre_i [LANES],
  output logic [LANES*dmpid_pkg::DRIVE_W-1:0]   tdata_o
);
  import dmpid_pkg::*;

  logic signed [PRE_W-1:0]       oc_s;
  logic signed [PRE_W-1:0]       lim [LANES];
  logic [LANES*DRIVE_W-1:0]      tdata_d, tdata_q;

  assign oc_s = $signed({{(PRE_W-CLAMP_W){1'b0}}, oclim_i});

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (pre_i[l] > oc_s) begin
        lim[l] = oc_s;
      end else if (pre_i[l] < -oc_s) begin
        lim[l] = -oc_s;
      end else begin
        lim[l] = pre_i[l];
      end
      tdata_d[l*DRIVE_W +: DRIVE_W] = zero_i ? '0 : DRIVE_W'(lim[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tdata_q <= tdata_d;
    end
  end

  assign tdata_o = tdata_q;

endmodule

// ----- rtl/dual_mode_pid_four_wheel_core.sv -----
// Top level of the four-wheel PID core: configuration registers, pipeline
// control and the lane array. Depends on dmpid_pkg, dmpid_lane, dmpid_merge.
//
// Each input item carries a measured and a target speed for every wheel plus
// a zero-mode flag in tuser; each item yields exactly one result item with
// one clamped Q16.16 drive value per wheel. The lanes run as a six-stage
// elastic pipeline (operand select, split multiply, recombine and integral
// limit, term sum, accumulator, output clamp), and a new item is accepted
// every cycle unless back-pressure from the output fills the pipeline; the
// error-state update in stage zero and the accumulator update in stage four
// are the only loops.
// tready drops only when every stage holds an item and the result is not
// taken. Registers may be written only while no item is in flight.
module dual_mode_pid_four_wheel_core #(
  parameter int unsigned LANES     = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [dmpid_pkg::IDX_W-1:0]              cfg_index_i,
  input  logic [dmpid_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // measured_0 .. measured_{LANES-1}, target_0 .. target_{LANES-1}, zero pad
  input  logic [((2*LANES*dmpid_pkg::MEAS_W+7)/8)*8-1:0] s_axis_tdata_i,
  // zero_mode
  input  logic                                     s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // drive_0 .. drive_{LANES-1}
  output logic [LANES*dmpid_pkg::DRIVE_W-1:0]      m_axis_tdata_o
);
  import dmpid_pkg::*;

  localparam int unsigned TermW = GAIN_W + X_W + 2 - FRAC_BITS;
  localparam int unsigned SumW  = TermW + 2;
  localparam int unsigned PreW  = (SumW > ACC_W) ? SumW : ACC_W;

  // Configuration registers.
  logic               incr_q;
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [CLAMP_W-1:0] iclamp_q, oclamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incr_q   <= 1'b1;
      gain_p_q <= RST_GAIN_P;
      gain_i_q <= RST_GAIN_I;
      gain_d_q <= RST_GAIN_D;
      iclamp_q <= RST_ICLAMP;
      oclamp_q <= RST_OCLAMP;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INCR_MODE: incr_q   <= cfg_wdata_i[0];
        CFG_GAIN_P:    gain_p_q <= cfg_wdata_i;
        CFG_GAIN_I:    gain_i_q <= cfg_wdata_i;
        CFG_GAIN_D:    gain_d_q <= cfg_wdata_i;
        CFG_ICLAMP:    iclamp_q <= cfg_wdata_i[CLAMP_W-1:0];
        CFG_OCLAMP:    oclamp_q <= cfg_wdata_i[CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Elastic pipeline control: a stage takes new data when it is empty or
  // when the stage after it moves on.
  logic [NSTG-1:0] valid_q, zero_q, en;
  logic            en_out, out_v_q;
  lane_ctl_t       ctl;

  always_comb begin
    en_out = !out_v_q || m_axis_tready_i;
    en[NSTG-1] = !valid_q[NSTG-1] || en_out;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
      if (en_out) begin
        out_v_q <= valid_q[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      zero_q[0] <= s_axis_tuser_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign ctl.load    = en;
  assign ctl.st_upd  = s_axis_tvalid_i && en[0] && !s_axis_tuser_i;
  assign ctl.acc_upd = en[NSTG-1] && valid_q[NSTG-2] && !zero_q[NSTG-2] && incr_q;
  assign ctl.incr    = incr_q;

  logic signed [PreW-1:0] pre [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dmpid_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .meas_i   ($signed(s_axis_tdata_i[l*MEAS_W +: MEAS_W])),
      .targ_i   ($signed(s_axis_tdata_i[(LANES+l)*MEAS_W +: MEAS_W])),
      .gain_p_i (gain_p_q),
      .gain_i_i (gain_i_q),
      .gain_d_i (gain_d_q),
      .ilim_i   (iclamp_q),
      .pre_o    (pre[l])
    );
  end

  dmpid_merge #(
    .LANES (LANES),
    .PRE_W (PreW)
  ) u_merge (
    .clk_i   (clk_i),
    .load_i  (en_out && valid_q[NSTG-1]),
    .zero_i  (zero_q[NSTG-1]),
    .oclim_i (oclamp_q),
    .pre_i   (pre),
    .tdata_o (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = out_v_q;

endmodule

// ----- rtl/dmpid_checker.sv -----
// Port-level checker of the wheel PID core, bound to the top level.
// Depends on dmpid_pkg and dual_mode_pid_four_wheel_core_assert.svh.
`include "dual_mode_pid_four_wheel_core_assert.svh"

module dmpid_checker #(
  parameter int unsigned LANES     = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     cfg_we_i,
  input logic [dmpid_pkg::IDX_W-1:0]              cfg_index_i,
  input logic [dmpid_pkg::CFG_W-1:0]              cfg_wdata_i,
  input logic                                     s_axis_tvalid_i,
  input logic                                     s_axis_tready_o,
  input logic [((2*LANES*dmpid_pkg::MEAS_W+7)/8)*8-1:0] s_axis_tdata_i,
  input logic                                     s_axis_tuser_i,
  input logic                                     m_axis_tvalid_o,
  input logic                                     m_axis_tready_i,
  input logic [LANES*dmpid_pkg::DRIVE_W-1:0]      m_axis_tdata_o
);
  import dmpid_pkg::*;

  // Shadow of the output limit, taken from the write port.
  logic [CLAMP_W-1:0]        oc_q;
  logic signed [DRIVE_W-1:0] oc_s;
  logic [2:0]                cnt_q;
  logic                      in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign oc_s    = $signed({1'b0, oc_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q  <= RST_OCLAMP;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CFG_OCLAMP) begin
        oc_q <= cfg_wdata_i[CLAMP_W-1:0];
      end
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  `DMPID_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result item changed while stalled")

  `DMPID_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !m_axis_tvalid_o || m_axis_tready_i, s_axis_tready_o, "input stalled although the output side is free")

  `DMPID_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, cnt_q == 3'd0, !m_axis_tvalid_o, "result item with no item in flight")

  for (genvar l = 0; l < LANES; l++) begin : g_lim
    `DMPID_ASSERT_IMP(a_drive_lim, clk_i, rst_ni, m_axis_tvalid_o, ($signed(m_axis_tdata_o[l*DRIVE_W +: DRIVE_W]) <= oc_s) && ($signed(m_axis_tdata_o[l*DRIVE_W +: DRIVE_W]) >= -oc_s), "drive value beyond the output limit")
  end

endmodule

bind dual_mode_pid_four_wheel_core dmpid_checker #(
  .LANES     (LANES),
  .FRAC_BITS (FRAC_BITS)
) u_dmpid_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking bench for the four-wheel PID core in positional and incremental form.
// It predicts every drive result internally and compares it field by field with the stream output.
// Depends on dmpid_pkg and dual_mode_pid_four_wheel_core only.
`timescale 1ns / 100ps

module testbench;
  import dmpid_pkg::*;

  localparam int unsigned LANES       = 4;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned TDATA_W     = ((2*LANES*MEAS_W+7)/8)*8;
  localparam int unsigned PHASES      = 16;
  localparam int unsigned PIPE_DRAIN  = 8;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned REPORT_CAP  = 200;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [MEAS_W-1:0] SPEED_MIN = 31'h4000_0000;
  localparam logic [MEAS_W-1:0] SPEED_MAX = 31'h3FFF_FFFF;
  localparam longint SPEED_LO  = -(longint'(1) <<< (MEAS_W-1));
  localparam longint SPEED_HI  = (longint'(1) <<< (MEAS_W-1)) - 1;
  localparam longint ACC_MAX   = (longint'(1) <<< (ACC_W-1)) - 1;
  localparam longint ACC_MIN   = -(longint'(1) <<< (ACC_W-1));
  localparam longint SUM_RAW   = longint'(ERR_SUM_BOUND) <<< FRAC_BITS;
  localparam longint SUM_LIMIT = (SUM_RAW > SUM_CAP) ? SUM_CAP : SUM_RAW;

  typedef struct packed {
    logic                           zero_mode;
    logic [LANES-1:0][MEAS_W-1:0]   target;
    logic [LANES-1:0][MEAS_W-1:0]   measured;
  } tick_t;

  typedef logic [LANES-1:0][DRIVE_W-1:0] drives_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [IDX_W-1:0]    cfg_index_i     = '0;
  logic [CFG_W-1:0]    cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // measured_0 .. measured_3, target_0 .. target_3
  logic [TDATA_W-1:0]  s_axis_tdata_i  = '0;
  // zero_mode
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // drive_0 .. drive_3
  logic [LANES*DRIVE_W-1:0] m_axis_tdata_o;

  dual_mode_pid_four_wheel_core #(
    .LANES     (LANES),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predictor copy of the registers and of the per-lane controller state.
  logic               mdl_incr;
  logic [GAIN_W-1:0]  mdl_kp, mdl_ki, mdl_kd;
  longint             mdl_iclamp, mdl_oclamp;
  longint             err_sum   [LANES];
  longint             err_prev  [LANES];
  longint             err_prev2 [LANES];
  longint             drive_acc [LANES];

  tick_t   pending_ticks_q [$];
  drives_t expected_drives_q [$];
  tick_t   offered_tick;

  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned src_gap_left  = 0;
  int unsigned sink_stall_left = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_req      = 0;
  int unsigned holds_done    = 0;
  int unsigned stall_cycles  = 0;

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned pos_ticks       = 0;
  int unsigned incr_ticks      = 0;
  int unsigned zero_ticks      = 0;
  int unsigned settings_count  = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // floor(gain * x / 2^FRAC_BITS), computed wide enough that nothing wraps.
  function automatic longint fixed_mul(input logic [GAIN_W-1:0] gain, input longint x);
    logic signed [99:0] gw;
    logic signed [99:0] xw;
    logic signed [99:0] prod;
    gw   = {68'd0, gain};
    xw   = 100'(x);
    prod = (gw * xw) >>> FRAC_BITS;
    return prod[63:0];
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Works out the drives for one tick and advances the controller state.
  function automatic drives_t predict_tick(input tick_t t);
    drives_t res;
    longint  meas, targ, e, e1, e2, p, ip, dp, drive;
    res = '0;
    if (t.zero_mode) return res;
    for (int l = 0; l < LANES; l++) begin
      meas = longint'($signed(t.measured[l]));
      targ = longint'($signed(t.target[l]));
      e    = targ - meas;
      e1   = err_prev[l];
      e2   = err_prev2[l];
      if (!mdl_incr) begin
        // The integral term uses the sum from before this tick.
        p  = fixed_mul(mdl_kp, e);
        ip = clamp_sym(fixed_mul(mdl_ki, err_sum[l]), mdl_iclamp);
        dp = fixed_mul(mdl_kd, e - e1);
        drive = clamp_sym(p + ip + dp, mdl_oclamp);
        err_sum[l] = clamp_sym(err_sum[l] + e, SUM_LIMIT);
      end else begin
        p  = fixed_mul(mdl_kp, e - e1);
        ip = clamp_sym(fixed_mul(mdl_ki, e), mdl_iclamp);
        dp = fixed_mul(mdl_kd, e - 2 * e1 + e2);
        drive_acc[l] = drive_acc[l] + p + ip + dp;
        if (drive_acc[l] > ACC_MAX) drive_acc[l] = ACC_MAX;
        if (drive_acc[l] < ACC_MIN) drive_acc[l] = ACC_MIN;
        drive = clamp_sym(drive_acc[l], mdl_oclamp);
      end
      err_prev2[l] = e1;
      err_prev[l]  = e;
      res[l] = drive[DRIVE_W-1:0];
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [MEAS_W-1:0] pick_speed();
    int unsigned roll;
    longint      v;
    roll = $urandom_range(0, 99);
    if (roll < 6) return SPEED_MIN;
    if (roll < 12) return SPEED_MAX;
    if (roll < 40) return MEAS_W'($urandom());
    v = longint'($urandom_range(0, 100 << 16)) - (50 << 16);
    return v[MEAS_W-1:0];
  endfunction

  function automatic tick_t random_tick();
    tick_t  t;
    longint v;
    t.zero_mode = ($urandom_range(0, 99) < 8);
    for (int l = 0; l < LANES; l++) begin
      t.measured[l] = pick_speed();
      if ($urandom_range(0, 99) < 70) begin
        // Target close to the measured speed, as in a settling loop.
        v = longint'($signed(t.measured[l])) + longint'($urandom_range(0, 4 << 16)) - (2 << 16);
        if (v > SPEED_HI) v = SPEED_HI;
        if (v < SPEED_LO) v = SPEED_LO;
        t.target[l] = v[MEAS_W-1:0];
      end else begin
        t.target[l] = pick_speed();
      end
    end
    return t;
  endfunction

  function automatic tick_t uniform_tick(input logic zero, input logic [MEAS_W-1:0] meas,
                                         input logic [MEAS_W-1:0] targ);
    tick_t t;
    t.zero_mode = zero;
    for (int l = 0; l < LANES; l++) begin
      t.measured[l] = meas;
      t.target[l]   = targ;
    end
    return t;
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1 << 17);
      3: return $urandom_range(0, 1 << 14);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_clamp();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1000 << 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_INCR_MODE: mdl_incr   = value[0];
      CFG_GAIN_P:    mdl_kp     = value[GAIN_W-1:0];
      CFG_GAIN_I:    mdl_ki     = value[GAIN_W-1:0];
      CFG_GAIN_D:    mdl_kd     = value[GAIN_W-1:0];
      CFG_ICLAMP:    mdl_iclamp = longint'(value[CLAMP_W-1:0]);
      CFG_OCLAMP:    mdl_oclamp = longint'(value[CLAMP_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  // Sampled on the falling edge so that the handshake updates of the rising edge have settled.
  task automatic wait_drained();
    while (pending_ticks_q.size() != 0 || s_axis_tvalid_i || expected_drives_q.size() != 0)
      @(negedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // Source side: offers queued items with random gaps and predicts each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_drives_q.push_back(predict_tick(offered_tick));
        if (offered_tick.zero_mode) zero_ticks++;
        else if (mdl_incr) incr_ticks++;
        else pos_ticks++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_ticks_q.size() > 0) begin
          offered_tick = pending_ticks_q.pop_front();
          s_axis_tdata_i  <= TDATA_W'({offered_tick.target, offered_tick.measured});
          s_axis_tuser_i  <= offered_tick.zero_mode;
          s_axis_tvalid_i <= 1'b1;
          src_gap_left = src_idle_en ? pick_gap() : 0;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks every result item and applies random stalls and long holds.
  always @(posedge clk_i) begin : sink
    drives_t want;
    drives_t got;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (expected_drives_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $error("drive result %h arrived with no tick outstanding", got);
        end else begin
          want = expected_drives_q.pop_front();
          results_checked++;
          for (int l = 0; l < LANES; l++) begin
            if (got[l] !== want[l]) begin
              mismatches++;
              if (mismatches <= REPORT_CAP)
                $error("drive_%0d: expected %0d, got %0d", l, $signed(want[l]), $signed(got[l]));
            end
          end
        end
      end
      if (holds_done < hold_req) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) hold_left--;
      else if (sink_stall_left > 0) sink_stall_left--;
      else if (sink_idle_en) sink_stall_left = pick_gap();
      m_axis_tready_i <= (hold_left == 0 && sink_stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_we_i) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned n_items;
    mdl_incr   = 1'b1;
    mdl_kp     = RST_GAIN_P;
    mdl_ki     = RST_GAIN_I;
    mdl_kd     = RST_GAIN_D;
    mdl_iclamp = longint'(RST_ICLAMP);
    mdl_oclamp = longint'(RST_OCLAMP);
    for (int l = 0; l < LANES; l++) begin
      err_sum[l]   = 0;
      err_prev[l]  = 0;
      err_prev2[l] = 0;
      drive_acc[l] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_count = 1;

    // Register values straight after reset, incremental form: full-scale error swings.
    @(negedge clk_i);
    pending_ticks_q.push_back(uniform_tick(1'b0, '0, '0));
    pending_ticks_q.push_back(uniform_tick(1'b0, SPEED_MIN, SPEED_MAX));
    pending_ticks_q.push_back(uniform_tick(1'b0, SPEED_MAX, SPEED_MIN));
    pending_ticks_q.push_back(uniform_tick(1'b1, SPEED_MIN, SPEED_MAX));
    pending_ticks_q.push_back(uniform_tick(1'b0, SPEED_MAX, SPEED_MIN));
    pending_ticks_q.push_back(uniform_tick(1'b0, '0, 31'(1 << 16)));
    pending_ticks_q.push_back(uniform_tick(1'b0, 31'(1 << 16), '0));
    pending_ticks_q.push_back(uniform_tick(1'b0, SPEED_MAX, SPEED_MAX));
    wait_drained();

    // Positional form selected through a value with upper bits set; spare indexes
    // are written after the gains so that any aliasing shows up in the drives.
    write_reg(CFG_INCR_MODE, 32'hFFFF_FFFE);
    write_reg(CFG_GAIN_P, 32'h0001_0000);
    write_reg(CFG_GAIN_I, 32'hFFFF_FFFF);
    write_reg(CFG_GAIN_D, 32'h0000_8000);
    write_reg(CFG_ICLAMP, 32'hFFFF_FFFF);
    write_reg(CFG_OCLAMP, 32'h8000_0000 | (1000 << 16));
    write_reg(CFG_SPARE_A, 32'h0000_0000);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    end_writes();
    @(negedge clk_i);
    // Repeated full-scale errors drive the error sum into its bound both ways.
    repeat (3) pending_ticks_q.push_back(uniform_tick(1'b0, SPEED_MIN, SPEED_MAX));
    pending_ticks_q.push_back(uniform_tick(1'b1, SPEED_MAX, SPEED_MIN));
    repeat (4) pending_ticks_q.push_back(uniform_tick(1'b0, SPEED_MAX, SPEED_MIN));
    pending_ticks_q.push_back(uniform_tick(1'b0, '0, '0));
    pending_ticks_q.push_back(uniform_tick(1'b0, '0, 31'(5 << 16)));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_INCR_MODE, $urandom());
      if (ph == 0) begin
        write_reg(CFG_GAIN_P, '1);
        write_reg(CFG_GAIN_I, '1);
        write_reg(CFG_GAIN_D, '1);
        write_reg(CFG_ICLAMP, '1);
        write_reg(CFG_OCLAMP, '1);
      end else if (ph == 1) begin
        write_reg(CFG_ICLAMP, '0);
        write_reg(CFG_OCLAMP, '0);
      end else begin
        if ($urandom_range(0, 9) < 7) write_reg(CFG_GAIN_P, pick_gain());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_GAIN_I, pick_gain());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_GAIN_D, pick_gain());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_ICLAMP, pick_clamp());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_OCLAMP, pick_clamp());
        if ($urandom_range(0, 9) < 2)
          write_reg(IDX_W'($urandom_range(CFG_SPARE_A, CFG_SPARE_B)), $urandom());
      end
      end_writes();
      @(negedge clk_i);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      // Hold the result side off long enough for the pipeline to fill and stall its input.
      if (ph == 2 || ph == 9) hold_req++;
      n_items = $urandom_range(90, 160);
      for (int k = 0; k < n_items; k++) pending_ticks_q.push_back(random_tick());
      wait_drained();
    end

    if (expected_drives_q.size() != 0) begin
      mismatches++;
      $error("%0d drive results never arrived", expected_drives_q.size());
    end
    $display("Ran %0d ticks (%0d positional, %0d incremental, %0d zero mode) over %0d register settings.",
             pos_ticks + incr_ticks + zero_ticks, pos_ticks, incr_ticks, zero_ticks, settings_count);
    $display("Compared %0d drive results lane by lane, with %0d long output holds.",
             results_checked, holds_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
